>>> rtl/salru_pkg.sv
// Shared types and constants for the set-associative LRU lookup unit.
// No dependencies; imported by the update logic and the top level.
package salru_pkg;

    // Width of the byte address field on the input stream
    localparam int ADDR_W = 48;
    // Width of the way number reported in a result
    localparam int WAY_OUT_W = 3;

    // One lookup result; hit sits in the lowest bit when packed
    typedef struct packed {
        logic [WAY_OUT_W-1:0] way_used;
        logic                 replaced_dirty;
        logic                 replaced_valid;
        logic                 hit;
    } salru_result_t;

    localparam int RESULT_W = $bits(salru_result_t);
    localparam int RESULT_BYTES_W = ((RESULT_W + 7) / 8) * 8;

    // floor(log2(v)), 0 for v <= 1
    function automatic int floor_log2(input int v);
        int n;
        int x;
        n = 0;
        x = v;
        while (x > 1) begin
            x = x >> 1;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

>>> rtl/set_assoc_cache_lru_lookup_unit.sv
// Set-associative cache tag lookup with true-LRU replacement and write-allocate.
// Uses salru_pkg, salru_row_mem and salru_update.
//
// Input stream (s_axis): one access per transfer; tdata carries the byte address,
// tuser carries the write flag. Output stream (m_axis): one result per access,
// carrying hit, replaced_valid, replaced_dirty and the way used.
//
// Each access reads the whole set row from the row memory into its read register,
// then compares tags, picks the way, updates ranks and writes the row back in the
// next cycle while loading the result register. A result is shown once the result
// register is loaded, and it transfers when the receiver is ready. A new access is
// taken in the cycle its predecessor's result is shown if the receiver is ready,
// but never while the previous access is still in its lookup, since each access
// reads one row and writes it back.
//
// After reset the block clears every one of the 2**k set rows, one row a cycle,
// where k = max(1, floor(log2(NUM_SETS))); s_axis_tready stays low
// meanwhile. When the receiver stalls, the result is held and no new access
// is taken until the result transfer completes.
module set_assoc_cache_lru_lookup_unit
    import salru_pkg::*;
#(
    parameter int NUM_SETS   = 64,
    parameter int WAYS       = 8,
    parameter int LINE_BYTES = 64,
    parameter int ADDR_BITS  = 48
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [ADDR_W-1:0]         s_axis_tdata,  // [47:0] address
    input  logic                      s_axis_tuser,  // [0] is_write
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [0] hit, [1] replaced_valid, [2] replaced_dirty, [5:3] way_used, [7:6] zero
    output logic [RESULT_BYTES_W-1:0] m_axis_tdata
);

    localparam int OFF_BITS = floor_log2(LINE_BYTES);
    localparam int IDX_BITS = floor_log2(NUM_SETS);
    localparam int EFF_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int TAG_RAW  = EFF_BITS - OFF_BITS - IDX_BITS;
    localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int SET_AW   = (IDX_BITS > 0) ? IDX_BITS : 1;
    localparam int ROWS     = 1 << SET_AW;
    localparam int AGE_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_W    = AGE_W;
    localparam int ROW_W    = WAYS * (2 + AGE_W + TAG_W);

    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - EFF_BITS);
    localparam logic [SET_AW-1:0] SET_MASK  = (IDX_BITS > 0) ? {SET_AW{1'b1}} : '0;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [SET_AW-1:0] clr_cnt_reg;
    logic [SET_AW-1:0] set_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic              wr_reg;
    logic              out_valid_reg;
    salru_result_t     out_data_reg;

    logic [ADDR_W-1:0] addr_m;
    logic [ADDR_W-1:0] line;
    logic [SET_AW-1:0] in_set;
    logic [TAG_W-1:0]  in_tag;
    logic              accept;

    logic              mem_we;
    logic [SET_AW-1:0] mem_waddr;
    logic [ROW_W-1:0]  mem_wdata;
    logic [ROW_W-1:0]  mem_rdata;

    logic [WAYS-1:0]       rd_valid;
    logic [WAYS-1:0]       rd_dirty;
    logic [WAYS*AGE_W-1:0] rd_age;
    logic [WAYS*TAG_W-1:0] rd_tag;
    logic [WAYS-1:0]       wr_valid;
    logic [WAYS-1:0]       wr_dirty;
    logic [WAYS*AGE_W-1:0] wr_age;
    logic [WAYS*TAG_W-1:0] wr_tag;
    salru_result_t         result;

    // Split the address: drop the line offset, then set index, then tag
    assign addr_m = s_axis_tdata & ADDR_MASK;
    assign line   = addr_m >> OFF_BITS;
    assign in_set = SET_AW'(line) & SET_MASK;
    assign in_tag = TAG_W'(line >> IDX_BITS);

    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == {SET_AW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + SET_AW'(1);
            end
            if (state_reg == ST_LOOK)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg <= in_set;
            tag_reg <= in_tag;
            wr_reg  <= s_axis_tuser;
        end
        if (state_reg == ST_LOOK)
        begin
            out_data_reg <= result;
        end
    end

    // Clear rows after reset, write back the updated row during lookup
    assign mem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_LOOK);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : set_reg;
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : {wr_tag, wr_age, wr_dirty, wr_valid};

    assign {rd_tag, rd_age, rd_dirty, rd_valid} = mem_rdata;

    salru_row_mem #(
        .DEPTH  (ROWS),
        .AW     (SET_AW),
        .DATA_W (ROW_W)
    ) u_row_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (in_set),
        .rdata (mem_rdata)
    );

    salru_update #(
        .WAYS  (WAYS),
        .AGE_W (AGE_W),
        .TAG_W (TAG_W),
        .WAY_W (WAY_W)
    ) u_update (
        .rd_valid (rd_valid),
        .rd_dirty (rd_dirty),
        .rd_age   (rd_age),
        .rd_tag   (rd_tag),
        .tag      (tag_reg),
        .is_write (wr_reg),
        .wr_valid (wr_valid),
        .wr_dirty (wr_dirty),
        .wr_age   (wr_age),
        .wr_tag   (wr_tag),
        .result   (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = RESULT_BYTES_W'(out_data_reg);

endmodule

>>> rtl/salru_row_mem.sv
// Row memory holding the tag, valid, dirty and age fields of all ways of a set.
// One write port, one read port, read data registered. No dependencies.
module salru_row_mem #(
    parameter int DEPTH  = 64,
    parameter int AW     = 6,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/salru_update.sv
// Tag compare, way selection and true-LRU rank update for one set row.
// Depends on salru_pkg for the result type.
module salru_update
    import salru_pkg::*;
#(
    parameter int WAYS  = 8,
    parameter int AGE_W = 3,
    parameter int TAG_W = 36,
    parameter int WAY_W = 3
) (
    input  logic [WAYS-1:0]       rd_valid,
    input  logic [WAYS-1:0]       rd_dirty,
    input  logic [WAYS*AGE_W-1:0] rd_age,
    input  logic [WAYS*TAG_W-1:0] rd_tag,
    input  logic [TAG_W-1:0]      tag,
    input  logic                  is_write,
    output logic [WAYS-1:0]       wr_valid,
    output logic [WAYS-1:0]       wr_dirty,
    output logic [WAYS*AGE_W-1:0] wr_age,
    output logic [WAYS*TAG_W-1:0] wr_tag,
    output salru_result_t         result
);

    localparam logic [AGE_W-1:0] OLDEST = AGE_W'(WAYS - 1);

    logic [WAYS-1:0]  match;
    logic             hit;
    logic             found;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] lru_way;
    logic [WAY_W-1:0] sel;
    logic [AGE_W-1:0] sel_age;
    logic             sel_dirty;
    logic             fill_free;

    always_comb
    begin
        hit      = 1'b0;
        found    = 1'b0;
        hit_way  = '0;
        free_way = '0;
        lru_way  = '0;
        // Scan from the top so the lowest-numbered way wins
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            match[i] = rd_valid[i] && (rd_tag[i*TAG_W +: TAG_W] == tag);
            if (match[i])
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(i);
            end
            if (!rd_valid[i])
            begin
                found    = 1'b1;
                free_way = WAY_W'(i);
            end
            // In a full set the ranks are distinct, so the oldest is unique
            if (rd_age[i*AGE_W +: AGE_W] == OLDEST)
            begin
                lru_way = WAY_W'(i);
            end
        end
    end

    assign fill_free = !hit && found;
    assign sel       = hit ? hit_way : (found ? free_way : lru_way);
    assign sel_age   = rd_age[sel*AGE_W +: AGE_W];
    assign sel_dirty = rd_dirty[sel];

    always_comb
    begin
        wr_valid = rd_valid;
        wr_dirty = rd_dirty;
        wr_tag   = rd_tag;
        wr_age   = rd_age;
        // Age every valid way younger than the touched one, or every valid way when filling a free way
        for (int i = 0; i < WAYS; i++)
        begin
            if ((WAY_W'(i) != sel) && rd_valid[i] &&
                (fill_free || (rd_age[i*AGE_W +: AGE_W] < sel_age)))
            begin
                wr_age[i*AGE_W +: AGE_W] = rd_age[i*AGE_W +: AGE_W] + AGE_W'(1);
            end
        end
        wr_age[sel*AGE_W +: AGE_W] = '0;
        wr_valid[sel]              = 1'b1;
        wr_dirty[sel]              = hit ? (sel_dirty | is_write) : is_write;
        wr_tag[sel*TAG_W +: TAG_W] = tag;
    end

    always_comb
    begin
        result.hit            = hit;
        result.replaced_valid = !hit && !found;
        result.replaced_dirty = !hit && !found && sel_dirty;
        result.way_used       = WAY_OUT_W'(sel);
    end

endmodule

>>> test/set_assoc_cache_lru_lookup_unit_test.sv
// Self-checking testbench for the set-associative LRU lookup unit.
// Holds its own tag/valid/dirty/rank model of the cache and checks every result.
// Depends on salru_pkg and set_assoc_cache_lru_lookup_unit.
module set_assoc_cache_lru_lookup_unit_test
    import salru_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETS        = 64;
    localparam int NWAYS       = 8;
    localparam int LINE        = 64;
    localparam int ABITS       = 48;
    localparam int OFF_W       = $clog2(LINE);
    localparam int IDX_W       = $clog2(SETS);
    localparam int TAG_W       = ABITS - OFF_W - IDX_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ACCESSES = 600;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [ADDR_W-1:0]         s_axis_tdata = '0;   // [47:0] address
    logic                      s_axis_tuser = 1'b0; // [0] is_write
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // [0] hit, [1] replaced_valid, [2] replaced_dirty, [5:3] way_used, [7:6] zero
    logic [RESULT_BYTES_W-1:0] m_axis_tdata;

    set_assoc_cache_lru_lookup_unit #(
        .NUM_SETS   (SETS),
        .WAYS       (NWAYS),
        .LINE_BYTES (LINE),
        .ADDR_BITS  (ABITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Cache contents as the block should hold them; rank 0 is most recent
    logic [TAG_W-1:0] line_tag   [SETS][NWAYS];
    bit               line_valid [SETS][NWAYS];
    bit               line_dirty [SETS][NWAYS];
    int unsigned      line_rank  [SETS][NWAYS];

    salru_result_t lookup_results_due[$];
    int            mismatches = 0;
    int unsigned   cycles = 0;
    int unsigned   burst_left;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic              wr;
        bit                typed;
        bit                hit;
        bit                rv;
        bit                rd;
        logic [2:0]        way;
    } access_row_t;

    // addr, write, typed, hit, replaced_valid, replaced_dirty, way
    access_row_t directed_rows [20] = '{
        '{48'h0000_0000_0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 3'd0},
        '{48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 3'd0},
        '{48'h0000_0000_003F, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 3'd0},
        '{48'h0000_0000_1000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 3'd1},
        '{48'h0000_0000_2000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 3'd2},
        '{48'h0000_0000_3000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 3'd3},
        '{48'h0000_0000_4000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 3'd4},
        '{48'h0000_0000_5000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 3'd5},
        '{48'h0000_0000_6000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 3'd6},
        '{48'h0000_0000_7000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 3'd7},
        // set 0 full: evict the dirty way 0
        '{48'h0000_0000_8000, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 3'd0},
        '{48'h0000_0000_1000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 3'd1},
        // way 2 is now least recent and clean
        '{48'h0000_0000_9000, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 3'd2},
        '{48'hFFFF_FFFF_FFC0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 3'd0},
        '{48'h8000_0000_0FC0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 3'd1},
        '{48'h5555_5555_5555, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0},
        '{48'hAAAA_AAAA_AAAA, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0},
        '{48'h5555_5555_5540, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0},
        '{48'hAAAA_AAAA_AA80, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0},
        '{48'h0000_0000_3000, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 3'd3}
    };

    // Bring way w to rank 0; ways that were more recent than it move down one
    function automatic void make_recent(input int set_idx, input int w,
                                        input int unsigned old_rank);
        for (int i = 0; i < NWAYS; i++)
            if (i != w && line_valid[set_idx][i] && line_rank[set_idx][i] < old_rank)
                line_rank[set_idx][i]++;
        line_rank[set_idx][w] = 0;
    endfunction

    function automatic salru_result_t predict_lookup(input logic [ADDR_W-1:0] a,
                                                     input logic wr);
        salru_result_t    r;
        int               set_idx;
        logic [TAG_W-1:0] t;
        int               w;
        bit               matched;
        bit               free_way;
        r = '0;
        set_idx = int'(a[OFF_W +: IDX_W]);
        t = a[OFF_W + IDX_W +: TAG_W];
        w = 0;
        matched = 1'b0;
        free_way = 1'b0;
        for (int i = 0; i < NWAYS; i++)
            if (!matched && line_valid[set_idx][i] && line_tag[set_idx][i] == t)
            begin
                w = i;
                matched = 1'b1;
            end
        if (matched)
        begin
            r.hit = 1'b1;
            make_recent(set_idx, w, line_rank[set_idx][w]);
            if (wr)
                line_dirty[set_idx][w] = 1'b1;
        end
        else
        begin
            for (int i = 0; i < NWAYS; i++)
                if (!free_way && !line_valid[set_idx][i])
                begin
                    w = i;
                    free_way = 1'b1;
                end
            if (free_way)
                make_recent(set_idx, w, NWAYS);
            else
            begin
                // full set: evict the lowest-numbered way of highest rank
                for (int i = 1; i < NWAYS; i++)
                    if (line_rank[set_idx][i] > line_rank[set_idx][w])
                        w = i;
                r.replaced_valid = 1'b1;
                r.replaced_dirty = line_dirty[set_idx][w];
                make_recent(set_idx, w, line_rank[set_idx][w]);
            end
            line_tag[set_idx][w] = t;
            line_valid[set_idx][w] = 1'b1;
            line_dirty[set_idx][w] = wr;
        end
        r.way_used = w[WAY_OUT_W-1:0];
        return r;
    endfunction

    // Offer one access, hold it until the transfer, then queue its result; pause after each burst
    task automatic push_access(input logic [ADDR_W-1:0] a, input logic wr, input bit typed,
                               input salru_result_t want);
        salru_result_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= a;
        s_axis_tuser  <= wr;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = predict_lookup(a, wr);
        lookup_results_due.push_back(typed ? want : predicted);
        burst_left--;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 4)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // Receiver stall pattern, cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        case (cycles[9:8])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= (cycles % 3 == 0);
            2'd2:    m_axis_tready <= ($urandom_range(0, 9) < 7);
            default: m_axis_tready <= (cycles[3:0] == 4'hF);
        endcase
        if (cycles == CYCLE_LIMIT)
        begin
            $display("set_assoc_cache_lru_lookup_unit: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        salru_result_t got;
        salru_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = salru_result_t'(m_axis_tdata[RESULT_W-1:0]);
            if (lookup_results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: hit=%0b rv=%0b rd=%0b way=%0d", got.hit,
                             got.replaced_valid, got.replaced_dirty, got.way_used);
            end
            else
            begin
                want = lookup_results_due.pop_front();
                if (got.hit !== want.hit || got.replaced_valid !== want.replaced_valid ||
                    got.replaced_dirty !== want.replaced_dirty ||
                    got.way_used !== want.way_used ||
                    m_axis_tdata[RESULT_BYTES_W-1:RESULT_W] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %h: expected hit=%0b rv=%0b rd=%0b way=%0d, ",
                                  "got hit=%0b rv=%0b rd=%0b way=%0d"},
                                 m_axis_tdata, want.hit, want.replaced_valid,
                                 want.replaced_dirty, want.way_used, got.hit,
                                 got.replaced_valid, got.replaced_dirty, got.way_used);
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        salru_result_t     want;
        logic [TAG_W-1:0]  tag_pool [12];
        int                hot_sets [4];
        logic [ADDR_W-1:0] a;
        int unsigned       pick;
        for (int i = 0; i < 12; i++)
            tag_pool[i] = TAG_W'({$urandom, $urandom});
        hot_sets = '{0, SETS - 1, $urandom_range(1, SETS - 2), $urandom_range(1, SETS - 2)};
        burst_left = $urandom_range(1, 30);
        wait (rst_n);
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            want = '0;
            want.hit = directed_rows[i].hit;
            want.replaced_valid = directed_rows[i].rv;
            want.replaced_dirty = directed_rows[i].rd;
            want.way_used = directed_rows[i].way;
            push_access(directed_rows[i].addr, directed_rows[i].wr, directed_rows[i].typed, want);
        end

        // Mostly a small working set over a few sets, so hits and evictions are frequent
        for (int n = 0; n < RANDOM_ACCESSES; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                a = {tag_pool[$urandom_range(0, 11)], IDX_W'(hot_sets[$urandom_range(0, 3)]),
                     OFF_W'($urandom)};
            else
                a = ADDR_W'({$urandom, $urandom});
            push_access(a, 1'($urandom), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (lookup_results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("set_assoc_cache_lru_lookup_unit: match");
        else
            $display("set_assoc_cache_lru_lookup_unit: mismatch");
        $finish;
    end

endmodule
